@@ rtl/dcr_pkg.sv @@
`default_nettype none

package dcr_pkg;

    // Sample path widths.
    localparam int RAW_W     = 32;
    localparam int PRE_SHIFT = 12;
    localparam int S_W       = RAW_W - PRE_SHIFT;
    localparam int FRAC_W    = 16;
    localparam int EST_W     = S_W + FRAC_W + 1;
    localparam int ALPHA_W   = 16;
    localparam int PROD_W    = EST_W + ALPHA_W + 1;
    localparam int Q_W       = EST_W - FRAC_W;
    localparam int SAT_W     = (S_W + 2 > 17) ? S_W + 2 : 17;
    localparam int CLEAN_W   = 16;

    // Framing widths.
    localparam int BYTE_W    = 8;
    localparam int CHUNK_W   = 13;
    localparam int POS_W     = 12;
    localparam int MAX_CHUNK = 4096;
    localparam int SLOT_W    = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(3);

    localparam logic [ALPHA_W-1:0] DC_ALPHA_RST    = ALPHA_W'(66);
    localparam logic [CHUNK_W-1:0] CHUNK_LEN_RST   = CHUNK_W'(512);
    localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST  = 8'hED;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST = 8'h0A;

    // Byte slots of one run, in stream order.
    localparam logic [SLOT_W-1:0] SLOT_SYNC0   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SYNC1   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_CNT_LO  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_CNT_HI  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DATA_LO = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_DATA_HI = 3'd5;

    // Framing settings handed to the byte framer.
    typedef struct packed {
        logic [BYTE_W-1:0]  sync_first;
        logic [BYTE_W-1:0]  sync_second;
        logic [CHUNK_W-1:0] chunk_len;
    } frame_cfg_t;

endpackage

`default_nettype wire

@@ rtl/dcr_if.sv @@
`default_nettype none

// Raw microphone word channel.
interface dcr_raw_if
    import dcr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

// Framed byte stream channel.
interface dcr_byte_if
    import dcr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_header;
    logic              run_last;

    modport source (output valid, output out_byte, output is_header, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header, input run_last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/dc_removing_pcm_framer.sv @@
// A raw word passes stage A, B (product) and C (estimate write-back, cleaning), then the
// framer output register; bytes leave at one byte per cycle while the sink is ready, and a
// word that opens a chunk is led by its header. A product waits for the last write-back.
// Reset: asynchronous, active low; registers return to defaults, the DC estimate reloads
// from the first sample and the next sample opens a chunk. No clearing pass is needed.
`default_nettype none

module dc_removing_pcm_framer
    import dcr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dcr_raw_if.sink                    raw,
    dcr_byte_if.source                 frame,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ALPHA_W-1:0] dc_alpha_reg;
    logic [CHUNK_W-1:0] chunk_len_reg;
    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;

    frame_cfg_t         fcfg;
    logic               smp_valid;
    logic               smp_ready;
    logic [CLEAN_W-1:0] smp_data;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_alpha_reg    <= DC_ALPHA_RST;
            chunk_len_reg   <= CHUNK_LEN_RST;
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DC_ALPHA:    dc_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                REG_CHUNK_LEN:   chunk_len_reg   <= cfg_data[CHUNK_W-1:0];
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data[BYTE_W-1:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_data[BYTE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        fcfg.sync_first  = sync_first_reg;
        fcfg.sync_second = sync_second_reg;
        fcfg.chunk_len   = chunk_len_reg;
    end

    // DC tracking and cleaning pipeline.
    dcr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .dc_alpha  (dc_alpha_reg),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data)
    );

    // Chunk header insertion and byte serialization.
    dcr_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .cfg       (fcfg),
        .frame     (frame)
    );

endmodule

`default_nettype wire

@@ rtl/dcr_core.sv @@
`default_nettype none

module dcr_core
    import dcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    dcr_raw_if.sink                 raw,
    input  wire logic [ALPHA_W-1:0] dc_alpha,
    output logic                    smp_valid,
    input  wire logic               smp_ready,
    output logic [CLEAN_W-1:0]      smp_data
);

    logic                     a_valid_reg;
    logic signed [S_W-1:0]    a_s_reg;
    logic                     b_valid_reg;
    logic signed [S_W-1:0]    b_s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     c_valid_reg;
    logic signed [S_W-1:0]    c_s_reg;
    logic signed [EST_W-1:0]  est_reg;
    logic                     dc_valid_reg;

    logic                     a_go;
    logic                     b_go;
    logic                     c_go;
    logic signed [EST_W-1:0]  a_target;
    logic signed [EST_W-1:0]  b_target;
    logic signed [EST_W-1:0]  diff;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [EST_W-1:0]  est_next;
    logic signed [Q_W-1:0]    ipart;
    logic signed [SAT_W-1:0]  cleaned;

    // Stage advance conditions. A new product waits until the estimate it
    // depends on has been written back.
    assign a_go      = a_valid_reg && !b_valid_reg;
    assign b_go      = b_valid_reg && (!c_valid_reg || c_go);
    assign c_go      = c_valid_reg && smp_ready;
    assign raw.ready = !a_valid_reg || a_go;
    assign smp_valid = c_valid_reg;

    // Distance to the target, scaled by alpha.
    assign a_target  = {a_s_reg[S_W-1], a_s_reg, {FRAC_W{1'b0}}};
    assign b_target  = {b_s_reg[S_W-1], b_s_reg, {FRAC_W{1'b0}}};
    assign diff      = a_target - est_reg;
    assign alpha_s   = {1'b0, dc_alpha};
    assign prod_next = diff * alpha_s;

    // Floor of the scaled step; the first sample loads the estimate outright.
    assign prod_sh  = prod_reg >>> FRAC_W;
    assign est_next = dc_valid_reg ? est_reg + prod_sh[EST_W-1:0] : b_target;

    // Integer part of the estimate toward zero, then subtract and saturate.
    always_comb
    begin
        ipart   = est_reg[EST_W-1:FRAC_W] +
                  Q_W'(est_reg[EST_W-1] && (est_reg[FRAC_W-1:0] != '0));
        cleaned = SAT_W'(c_s_reg) - SAT_W'(ipart);
        if (cleaned > SAT_W'(32767))
        begin
            smp_data = CLEAN_W'(16'h7FFF);
        end
        else if (cleaned < -SAT_W'(32768))
        begin
            smp_data = CLEAN_W'(16'h8000);
        end
        else
        begin
            smp_data = cleaned[CLEAN_W-1:0];
        end
    end

    // Stage valid flags and the loaded flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            dc_valid_reg <= 1'b0;
        end
        else
        begin
            if (raw.valid && raw.ready)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_go)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_go)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_go)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_go)
            begin
                c_valid_reg  <= 1'b1;
                dc_valid_reg <= 1'b1;
            end
            else if (c_go)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    // Sample, product and estimate payload.
    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            a_s_reg <= raw.raw_word[RAW_W-1:PRE_SHIFT];
        end
        if (a_go)
        begin
            b_s_reg  <= a_s_reg;
            prod_reg <= prod_next;
        end
        if (b_go)
        begin
            c_s_reg <= b_s_reg;
            est_reg <= est_next;
        end
    end

    // Once loaded, the estimate stays loaded until reset.
    a_dc_loaded_holds: assert property (@(posedge clk) disable iff (!rst_n)
        dc_valid_reg |=> dc_valid_reg)
        else $error("DC estimate lost its loaded state");

    // The first load always lands together with a sample in the last stage.
    a_first_load_in_c: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dc_valid_reg) |-> c_valid_reg)
        else $error("DC estimate loaded without a sample behind it");

    // A product is never formed while a write-back is pending.
    a_no_stale_product: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_go) |=> b_valid_reg && $stable(prod_reg))
        else $error("Pending product was overwritten");

endmodule

`default_nettype wire

@@ rtl/dcr_framer.sv @@
`default_nettype none

module dcr_framer
    import dcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               smp_valid,
    output logic                    smp_ready,
    input  wire logic [CLEAN_W-1:0] smp_data,
    input  wire frame_cfg_t         cfg,
    dcr_byte_if.source              frame
);

    logic               d_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CLEAN_W-1:0] word_reg;
    logic [POS_W-1:0]   pos_reg;

    logic               out_go;
    logic               last;
    logic [CHUNK_W-1:0] eff;
    logic [CHUNK_W-1:0] pos_inc;
    logic [POS_W-1:0]   pos_next;

    assign out_go    = frame.valid && frame.ready;
    assign last      = (slot_reg == SLOT_DATA_HI);
    assign smp_ready = !d_valid_reg || (out_go && last);

    // Effective chunk length: zero counts as one, large values clamp.
    always_comb
    begin
        if (cfg.chunk_len == '0)
        begin
            eff = CHUNK_W'(1);
        end
        else if (cfg.chunk_len > CHUNK_W'(MAX_CHUNK))
        begin
            eff = CHUNK_W'(MAX_CHUNK);
        end
        else
        begin
            eff = cfg.chunk_len;
        end
    end

    // Position within the chunk after this sample.
    assign pos_inc  = {1'b0, pos_reg} + CHUNK_W'(1);
    assign pos_next = (pos_inc >= eff) ? '0 : pos_inc[POS_W-1:0];

    // Byte selection for the current slot.
    always_comb
    begin
        case (slot_reg)
            SLOT_SYNC0:   frame.out_byte = cfg.sync_first;
            SLOT_SYNC1:   frame.out_byte = cfg.sync_second;
            SLOT_CNT_LO:  frame.out_byte = eff[BYTE_W-1:0];
            SLOT_CNT_HI:  frame.out_byte = BYTE_W'(eff >> BYTE_W);
            SLOT_DATA_LO: frame.out_byte = word_reg[BYTE_W-1:0];
            SLOT_DATA_HI: frame.out_byte = word_reg[CLEAN_W-1:BYTE_W];
            default:      frame.out_byte = '0;
        endcase
    end

    assign frame.valid     = d_valid_reg;
    assign frame.is_header = slot_reg inside {SLOT_SYNC0, SLOT_SYNC1, SLOT_CNT_LO, SLOT_CNT_HI};
    assign frame.run_last  = last;

    // Output register control: a run starts with the header when the
    // sample opens a chunk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            slot_reg    <= SLOT_DATA_LO;
            pos_reg     <= '0;
        end
        else
        begin
            if (smp_valid && smp_ready)
            begin
                d_valid_reg <= 1'b1;
                slot_reg    <= (pos_reg == '0) ? SLOT_SYNC0 : SLOT_DATA_LO;
                pos_reg     <= pos_next;
            end
            else if (out_go)
            begin
                if (last)
                begin
                    d_valid_reg <= 1'b0;
                end
                else
                begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    // Sample word held for its two data beats.
    always_ff @(posedge clk)
    begin
        if (smp_valid && smp_ready)
        begin
            word_reg <= smp_data;
        end
    end

    // The beats of one run follow without a gap in the valid signal.
    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_go && !last) |=> frame.valid)
        else $error("Byte run ended before its last beat");

    // The count high byte is always followed by the low data byte.
    a_header_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_go && slot_reg == SLOT_CNT_HI) |=> (slot_reg == SLOT_DATA_LO))
        else $error("Header not followed by sample data");

    // A header run only starts at the beginning of a chunk.
    a_header_at_chunk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && smp_ready && pos_reg != '0) |=> (slot_reg == SLOT_DATA_LO))
        else $error("Header emitted in the middle of a chunk");

endmodule

`default_nettype wire
